/* hw/rtl/adaptive_warped_lattice_analysis_defines.svh */
// Assertion macros for the warped lattice analysis block
`ifndef ADAPTIVE_WARPED_LATTICE_ANALYSIS_DEFINES_SVH
`define ADAPTIVE_WARPED_LATTICE_ANALYSIS_DEFINES_SVH
`ifndef SYNTH
`define AWLA_ASSERT_NOW(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("%m: check failed");
`define AWLA_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("%m: check failed");
`else
`define AWLA_ASSERT_NOW(lbl, cond, prop)
`define AWLA_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

/* hw/rtl/awla_pkg.sv */
// Shared types, constants and saturation helpers for the lattice analysis block
`timescale 1ns / 1ps
`default_nettype none
package awla_pkg;

   localparam int STAGE_COUNT_DEFAULT = 7;
   localparam int SIG_W = 24;
   localparam int ACC_W = 40;
   localparam int OP_W  = 26;
   localparam int MAC_W = 68;

   localparam logic [ACC_W-1:0] DEN_OFFSET = 40'd274878;
   localparam logic [SIG_W-1:0] LEAK_RESET = 24'd16568289;
   localparam logic signed [SIG_W-1:0] WARP_RESET = -24'sd7345904;

   localparam logic REG_LEAK = 1'b0;
   localparam logic REG_WARP = 1'b1;

   typedef struct packed {
      logic en;
      logic clr;
      logic shift;
   } mac_ctl_type;

   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [MAC_W-1:0] v);
      logic [MAC_W-SIG_W:0] top_bits;
      top_bits = v[MAC_W-1:SIG_W-1];
      if ((&top_bits) || !(|top_bits)) return v[SIG_W-1:0];
      else if (v[MAC_W-1]) return {1'b1, {(SIG_W-1){1'b0}}};
      else return {1'b0, {(SIG_W-1){1'b1}}};
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [MAC_W-1:0] v);
      logic [MAC_W-ACC_W:0] top_bits;
      top_bits = v[MAC_W-1:ACC_W-1];
      if ((&top_bits) || !(|top_bits)) return v[ACC_W-1:0];
      else if (v[MAC_W-1]) return {1'b1, {(ACC_W-1){1'b0}}};
      else return {1'b0, {(ACC_W-1){1'b1}}};
   endfunction

   function automatic logic signed [MAC_W-1:0] ext_sig(input logic signed [SIG_W-1:0] v);
      return {{(MAC_W-SIG_W){v[SIG_W-1]}}, v};
   endfunction

   function automatic logic signed [OP_W-1:0] op_sig(input logic signed [SIG_W-1:0] v);
      return {{(OP_W-SIG_W){v[SIG_W-1]}}, v};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/awla_mac.sv */
// Shared multiply-accumulate unit with optional 24-bit left shift of the product
`timescale 1ns / 1ps
`default_nettype none
module awla_mac (
   input  wire logic                                    clock,
   input  wire awla_pkg::mac_ctl_type                   ctl,
   input  wire logic signed [awla_pkg::OP_W-1:0]        op_a,
   input  wire logic signed [awla_pkg::OP_W-1:0]        op_b,
   output logic signed [awla_pkg::MAC_W-1:0]            acc
);
   logic signed [2*awla_pkg::OP_W-1:0] prod;
   logic signed [awla_pkg::MAC_W-1:0]  prod_ext;
   logic signed [awla_pkg::MAC_W-1:0]  addend;
   logic signed [awla_pkg::MAC_W-1:0]  acc_ff;
   logic signed [awla_pkg::MAC_W-1:0]  acc_in;

   always_comb begin
      prod     = op_a * op_b;
      prod_ext = awla_pkg::MAC_W'(prod);
      addend   = ctl.shift ? (prod_ext <<< 24) : prod_ext;
      acc_in   = (ctl.clr ? '0 : acc_ff) + addend;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

/* hw/rtl/awla_div.sv */
// Restoring divider: correlation * 2^22 / denominator, truncated, saturated to 24 bits
`timescale 1ns / 1ps
`default_nettype none
module awla_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [awla_pkg::ACC_W-1:0]     num,
   input  wire logic [awla_pkg::ACC_W-1:0]            den,
   output logic                                       done,
   output logic signed [awla_pkg::SIG_W-1:0]          quot
);
   typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_type;

   div_state_type                   state_ff, state_in;
   logic [4:0]                      cnt_ff, cnt_in;
   logic [awla_pkg::ACC_W-1:0]      rem_ff, rem_in;
   logic [awla_pkg::ACC_W-1:0]      den_ff, den_in;
   logic [awla_pkg::SIG_W-1:0]      bits_ff, bits_in;
   logic [awla_pkg::SIG_W-1:0]      q_ff, q_in;
   logic                            ovf_ff, ovf_in;
   logic                            neg_ff, neg_in;
   logic [awla_pkg::ACC_W-1:0]      mag;
   logic [awla_pkg::ACC_W:0]        trial;
   logic                            fits;
   logic                            big;

   always_comb begin
      mag      = num[awla_pkg::ACC_W-1] ? (~num + 1'b1) : num;
      trial    = {rem_ff, bits_ff[awla_pkg::SIG_W-1]};
      fits     = trial >= {1'b0, den_ff};
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      bits_in  = bits_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               rem_in   = {2'b00, mag[awla_pkg::ACC_W-1:2]};
               bits_in  = {mag[1:0], {(awla_pkg::SIG_W-2){1'b0}}};
               den_in   = den;
               ovf_in   = {2'b00, mag[awla_pkg::ACC_W-1:2]} >= den;
               neg_in   = num[awla_pkg::ACC_W-1];
               q_in     = '0;
               cnt_in   = 5'(awla_pkg::SIG_W);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in  = fits ? awla_pkg::ACC_W'(trial - {1'b0, den_ff})
                           : trial[awla_pkg::ACC_W-1:0];
            q_in    = {q_ff[awla_pkg::SIG_W-2:0], fits};
            bits_in = {bits_ff[awla_pkg::SIG_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      big  = ovf_ff | q_ff[awla_pkg::SIG_W-1];
      done = state_ff == DIV_DONE;
      if (neg_ff) begin
         quot = big ? {1'b1, {(awla_pkg::SIG_W-1){1'b0}}} : (~q_ff + 1'b1);
      end else begin
         quot = big ? {1'b0, {(awla_pkg::SIG_W-1){1'b1}}} : q_ff;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/adaptive_warped_lattice_analysis.sv */
// Top level: adaptive warped lattice analysis with a shared MAC and iterative divider
//
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid/req_ready  | sample_in, buffer_slot
//  rsp      | out       | rsp_valid/rsp_ready  | stage_index, reflection_coef, residual_out,
//           |           |                      | slot_out, last_result
//  csr      | in/out    | APB psel/penable     | leak_factor (0x0), warp_factor (0x4)
//
// One item holds the block from its accepting edge until its last stage result is taken,
// so a new item is accepted only once the block is idle again. Each stage makes 15 passes
// through the shared MAC, runs the divider (24 steps and a done state) and emits a result.
// Reset (synchronous, active high) clears all stage state and loads register defaults.
// req_ready is high only while idle; a stalled result holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_warped_lattice_analysis_defines.svh"
module adaptive_warped_lattice_analysis #(
   parameter int STAGE_COUNT = awla_pkg::STAGE_COUNT_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [awla_pkg::SIG_W-1:0]     req_sample_in,
   input  wire logic [15:0]                           req_buffer_slot,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [2:0]                                 rsp_stage_index,
   output logic signed [awla_pkg::SIG_W-1:0]          rsp_reflection_coef,
   output logic signed [awla_pkg::SIG_W-1:0]          rsp_residual_out,
   output logic [15:0]                                rsp_slot_out,
   output logic                                       rsp_last_result,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [2:0]                            paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);
   localparam int STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
   localparam int SW    = awla_pkg::SIG_W;
   localparam int AW    = awla_pkg::ACC_W;
   localparam int MW    = awla_pkg::MAC_W;
   localparam int OW    = awla_pkg::OP_W;

   // Sequencer: one state per MAC pass, plus idle, emphasis, capture, divider hand-off, emit
   typedef enum logic [4:0] {
      S_IDLE, S_EMPH, S_SQ, S_E1, S_E2, S_E3, S_E4, S_WARP, S_FC, S_CR,
      S_C1, S_C2, S_C3, S_C4, S_DIVS, S_DIVGO, S_DIVW, S_K1, S_K2, S_SM,
      S_NB, S_NA, S_UPD, S_EMIT
   } seq_state_type;

   seq_state_type              state_ff, state_in;
   logic [STG_W-1:0]           stage_ff, stage_in;
   logic signed [SW-1:0]       x_ff, x_in;
   logic [15:0]                slot_ff, slot_in;
   logic signed [SW-1:0]       prev_ff, prev_in;
   logic signed [SW-1:0]       fa_ff, fa_in;
   logic signed [SW-1:0]       fb_ff, fb_in;
   logic signed [SW-1:0]       fc_ff, fc_in;
   logic signed [SW-1:0]       nfb_ff, nfb_in;
   logic signed [AW-1:0]       tmp_ff, tmp_in;
   logic signed [SW-1:0]       ratio_ff, ratio_in;
   logic signed [SW-1:0]       sm_ff, sm_in;
   logic [SW-1:0]              leak_ff, leak_in;
   logic signed [SW-1:0]       warp_ff, warp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 rsp_idx_ff, rsp_idx_in;
   logic signed [SW-1:0]       rsp_coef_ff, rsp_coef_in;
   logic signed [SW-1:0]       rsp_res_ff, rsp_res_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic signed [AW-1:0]       energy_ff [STAGE_COUNT];
   logic signed [AW-1:0]       corr_ff   [STAGE_COUNT];
   logic signed [SW-1:0]       wpo_ff    [STAGE_COUNT];
   logic signed [SW-1:0]       wpi_ff    [STAGE_COUNT];
   logic signed [SW-1:0]       coef_ff   [STAGE_COUNT];

   awla_pkg::mac_ctl_type      mac_ctl;
   logic signed [OW-1:0]       op_a, op_b;
   logic signed [MW-1:0]       acc;
   logic signed [MW-1:0]       acc_sh8, acc_sh22, acc_sh23, acc_sh24;

   logic                       div_start, div_done;
   logic signed [SW-1:0]       div_quot;
   logic [AW-1:0]              div_den;

   logic signed [AW-1:0]       e_sel, c_sel;
   logic [SW:0]                oma;
   logic signed [OW-1:0]       alpha_op, oma_op;
   logic signed [SW-1:0]       emph, fc_new, nfb_new, nfa_new, sm_new;
   logic signed [AW-1:0]       acc_new;
   logic                       last_stage;
   logic                       csr_write;

   awla_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   awla_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (c_sel),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Shared datapath views: stage state at the current stage, shifted accumulator
   always_comb begin
      e_sel      = energy_ff[stage_ff];
      c_sel      = corr_ff[stage_ff];
      oma        = 25'd16777216 - {1'b0, leak_ff};
      alpha_op   = OW'({1'b0, leak_ff});
      oma_op     = OW'(oma);
      acc_sh8    = acc >>> 8;
      acc_sh22   = acc >>> 22;
      acc_sh23   = acc >>> 23;
      acc_sh24   = acc >>> 24;
      acc_new    = awla_pkg::sat_acc(acc_sh24);
      emph       = awla_pkg::sat_sig(awla_pkg::ext_sig(x_ff) - awla_pkg::ext_sig(prev_ff));
      fc_new     = awla_pkg::sat_sig(acc_sh23 + awla_pkg::ext_sig(wpi_ff[stage_ff]));
      nfb_new    = awla_pkg::sat_sig(awla_pkg::ext_sig(fc_ff) - acc_sh22);
      nfa_new    = awla_pkg::sat_sig(awla_pkg::ext_sig(fa_ff) - acc_sh22);
      sm_new     = awla_pkg::sat_sig(acc_sh24);
      // Energy never goes negative, so the offset sum stays within 40 bits
      div_den    = e_sel + awla_pkg::DEN_OFFSET;
      last_stage = stage_ff == STG_W'(STAGE_COUNT - 1);
      csr_write  = psel & penable & pwrite;
   end

   // MAC operand and control select per sequencer step
   always_comb begin
      mac_ctl   = '{en: 1'b0, clr: 1'b0, shift: 1'b0};
      op_a      = '0;
      op_b      = '0;
      div_start = 1'b0;
      case (state_ff)
         S_SQ: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = awla_pkg::op_sig(fa_ff);
            op_b    = awla_pkg::op_sig(fa_ff);
         end
         S_E1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = OW'({1'b0, e_sel[SW-1:0]});
            op_b    = alpha_op;
         end
         S_E2: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
            op_a    = OW'(signed'(e_sel[AW-1:SW]));
            op_b    = alpha_op;
         end
         S_E3, S_C3: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
            op_a    = OW'({1'b0, tmp_ff[SW-1:0]});
            op_b    = oma_op;
         end
         S_E4, S_C4: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
            op_a    = OW'(signed'(tmp_ff[AW-1:SW]));
            op_b    = oma_op;
         end
         S_WARP: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = awla_pkg::op_sig(fb_ff) - awla_pkg::op_sig(wpo_ff[stage_ff]);
            op_b    = awla_pkg::op_sig(warp_ff);
         end
         S_CR: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = awla_pkg::op_sig(fa_ff);
            op_b    = awla_pkg::op_sig(fc_ff);
         end
         S_C1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = OW'({1'b0, c_sel[SW-1:0]});
            op_b    = alpha_op;
         end
         S_C2: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
            op_a    = OW'(signed'(c_sel[AW-1:SW]));
            op_b    = alpha_op;
         end
         S_DIVGO: div_start = 1'b1;
         S_K1: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = awla_pkg::op_sig(ratio_ff);
            op_b    = oma_op;
         end
         S_K2: begin
            mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
            op_a    = awla_pkg::op_sig(coef_ff[stage_ff]);
            op_b    = alpha_op;
         end
         S_NB: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = awla_pkg::op_sig(sm_ff);
            op_b    = awla_pkg::op_sig(fa_ff);
         end
         S_NA: begin
            mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
            op_a    = awla_pkg::op_sig(sm_ff);
            op_b    = awla_pkg::op_sig(fc_ff);
         end
         default: begin
            mac_ctl = '{en: 1'b0, clr: 1'b0, shift: 1'b0};
         end
      endcase
   end

   // Next-state logic for the sequencer and its scalar registers
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      x_in         = x_ff;
      slot_in      = slot_ff;
      prev_in      = prev_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      fc_in        = fc_ff;
      nfb_in       = nfb_ff;
      tmp_in       = tmp_ff;
      ratio_in     = ratio_ff;
      sm_in        = sm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;
      leak_in      = leak_ff;
      warp_in      = warp_ff;

      if (csr_write) begin
         case (paddr[2])
            awla_pkg::REG_LEAK: leak_in = pwdata[SW-1:0];
            awla_pkg::REG_WARP: warp_in = pwdata[SW-1:0];
            default:            leak_in = leak_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               slot_in  = req_buffer_slot;
               state_in = S_EMPH;
            end
         end
         S_EMPH: begin
            fa_in    = emph;
            fb_in    = emph;
            prev_in  = emph;
            stage_in = '0;
            state_in = S_SQ;
         end
         S_SQ: state_in = S_E1;
         S_E1: begin
            tmp_in   = acc_sh8[AW-1:0];
            state_in = S_E2;
         end
         S_E2:  state_in = S_E3;
         S_E3:  state_in = S_E4;
         S_E4:  state_in = S_WARP;
         S_WARP: state_in = S_FC;
         S_FC: begin
            fc_in    = fc_new;
            state_in = S_CR;
         end
         S_CR: state_in = S_C1;
         S_C1: begin
            tmp_in   = acc_sh8[AW-1:0];
            state_in = S_C2;
         end
         S_C2:    state_in = S_C3;
         S_C3:    state_in = S_C4;
         S_C4:    state_in = S_DIVS;
         S_DIVS:  state_in = S_DIVGO;
         S_DIVGO: state_in = S_DIVW;
         S_DIVW: begin
            if (div_done) begin
               ratio_in = div_quot;
               state_in = S_K1;
            end
         end
         S_K1: state_in = S_K2;
         S_K2: state_in = S_SM;
         S_SM: begin
            sm_in    = sm_new;
            state_in = S_NB;
         end
         S_NB: state_in = S_NA;
         S_NA: begin
            nfb_in   = nfb_new;
            state_in = S_UPD;
         end
         S_UPD: begin
            // Advance the forward and backward paths; load the result
            fa_in        = nfa_new;
            fb_in        = nfb_ff;
            rsp_valid_in = 1'b1;
            rsp_idx_in   = 3'(stage_ff);
            rsp_coef_in  = sm_ff;
            rsp_res_in   = last_stage ? nfa_new : '0;
            rsp_last_in  = last_stage;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            // Hold until the result is taken
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (last_stage) begin
                  state_in = S_IDLE;
               end else begin
                  stage_in = stage_ff + 1'b1;
                  state_in = S_SQ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         leak_ff      <= awla_pkg::LEAK_RESET;
         warp_ff      <= awla_pkg::WARP_RESET;
         for (int i = 0; i < STAGE_COUNT; i++) begin
            energy_ff[i] <= '0;
            corr_ff[i]   <= '0;
            wpo_ff[i]    <= '0;
            wpi_ff[i]    <= '0;
            coef_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         leak_ff      <= leak_in;
         warp_ff      <= warp_in;
         if (state_ff == S_WARP) begin
            energy_ff[stage_ff] <= acc_new;
         end
         if (state_ff == S_FC) begin
            wpo_ff[stage_ff] <= fc_new;
            wpi_ff[stage_ff] <= fb_ff;
         end
         if (state_ff == S_DIVS) begin
            corr_ff[stage_ff] <= acc_new;
         end
         if (state_ff == S_SM) begin
            coef_ff[stage_ff] <= sm_new;
         end
      end
      x_ff        <= x_in;
      slot_ff     <= slot_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      fc_ff       <= fc_in;
      nfb_ff      <= nfb_in;
      tmp_ff      <= tmp_in;
      ratio_ff    <= ratio_in;
      sm_ff       <= sm_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Register read-back
   always_comb begin
      case (paddr[2])
         awla_pkg::REG_LEAK: prdata = {8'd0, leak_ff};
         awla_pkg::REG_WARP: prdata = {{8{warp_ff[SW-1]}}, warp_ff};
         default:            prdata = '0;
      endcase
   end

   assign pready              = 1'b1;
   assign req_ready           = state_ff == S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stage_index     = rsp_idx_ff;
   assign rsp_reflection_coef = rsp_coef_ff;
   assign rsp_residual_out    = rsp_res_ff;
   assign rsp_slot_out        = slot_ff;
   assign rsp_last_result     = rsp_last_ff;

   `AWLA_ASSERT_NOW(a_no_accept_while_emit, rsp_valid, !req_ready)
   `AWLA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready && !rsp_valid)
   `AWLA_ASSERT_NOW(a_last_index, rsp_valid && rsp_last_result, rsp_stage_index == 3'(STAGE_COUNT - 1))
   `AWLA_ASSERT_NOW(a_residual_only_last, rsp_valid && !rsp_last_result, rsp_residual_out == '0)
endmodule
`default_nettype wire

/* tb/adaptive_warped_lattice_analysis_test.sv */
// Adaptive warped lattice analysis testbench: directed and random stimulus, scoreboard check
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: holds the lattice state and the queue of predicted stage results
class lattice_scoreboard;
   typedef struct {
      logic [2:0]         stage;
      logic signed [23:0] coef;
      logic signed [23:0] resid;
      logic [15:0]        slot;
      logic               last;
   } stage_result_type;

   localparam int NSTAGE = 7;
   localparam longint SMAX = 64'sd8388607;
   localparam longint SMIN = -64'sd8388608;
   localparam longint AMAX = 64'sd549755813887;
   localparam longint AMIN = -64'sd549755813888;
   localparam longint DOFS = 64'sd274878;

   stage_result_type pending[$];
   longint leak;
   longint warp;
   longint emph_prev;
   longint energy[NSTAGE];
   longint corr[NSTAGE];
   longint warp_out[NSTAGE];
   longint warp_in[NSTAGE];
   longint coef_sm[NSTAGE];
   int mismatches;

   function new();
      leak = 16568289;
      warp = -7345904;
      emph_prev = 0;
      mismatches = 0;
      foreach (energy[i]) begin
         energy[i] = 0; corr[i] = 0; warp_out[i] = 0; warp_in[i] = 0; coef_sm[i] = 0;
      end
   endfunction

   // arithmetic shift right is floor division for signed longint
   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function void set_leak(logic [23:0] v);
      leak = v;
   endfunction

   function void set_warp(logic signed [23:0] v);
      warp = v;
   endfunction

   // Run one sample through pre-emphasis and all stages, queue seven results
   function void note_sample(logic signed [23:0] smp, logic [15:0] slot);
      longint fa, fb, oma, sq, fc, cr, den, ratio, sm, nfa, nfb;
      stage_result_type r;
      oma = 64'sd16777216 - leak;
      fa = clamp(longint'(smp) - emph_prev, SMIN, SMAX);
      emph_prev = fa;
      fb = fa;
      for (int i = 0; i < NSTAGE; i++) begin
         sq = (fa * fa) >>> 8;
         energy[i] = clamp((energy[i] * leak + sq * oma) >>> 24, AMIN, AMAX);
         fc = clamp((((fb - warp_out[i]) * warp) >>> 23) + warp_in[i], SMIN, SMAX);
         warp_out[i] = fc;
         warp_in[i] = fb;
         cr = (fa * fc) >>> 8;
         corr[i] = clamp((corr[i] * leak + cr * oma) >>> 24, AMIN, AMAX);
         den = energy[i] + DOFS;
         if (den <= 0) den = DOFS;
         ratio = clamp((corr[i] * 64'sd4194304) / den, SMIN, SMAX);
         sm = clamp((ratio * oma + coef_sm[i] * leak) >>> 24, SMIN, SMAX);
         coef_sm[i] = sm;
         nfb = clamp(fc - ((sm * fa) >>> 22), SMIN, SMAX);
         nfa = clamp(fa - ((sm * fc) >>> 22), SMIN, SMAX);
         fb = nfb;
         fa = nfa;
         r.stage = i[2:0];
         r.coef = sm[23:0];
         r.slot = slot;
         r.last = (i == NSTAGE - 1);
         r.resid = r.last ? fa[23:0] : 24'sd0;
         pending.push_back(r);
      end
   endfunction

   function void check_result(logic [2:0] stage, logic signed [23:0] coef,
                              logic signed [23:0] resid, logic [15:0] slot, logic last);
      stage_result_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result: stage %0d coef %0d", stage, coef);
         return;
      end
      e = pending.pop_front();
      if (e.stage !== stage || e.coef !== coef || e.resid !== resid || e.slot !== slot
          || e.last !== last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp st %0d coef %0d res %0d slot %0d last %0d / got %0d %0d %0d %0d %0d",
                     e.stage, e.coef, e.resid, e.slot, e.last, stage, coef, resid, slot, last);
      end
   endfunction
endclass

module adaptive_warped_lattice_analysis_test;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [23:0] req_sample_in = '0;
   logic [15:0] req_buffer_slot = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_stage_index;
   logic signed [23:0] rsp_reflection_coef;
   logic signed [23:0] rsp_residual_out;
   logic [15:0] rsp_slot_out;
   logic rsp_last_result;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   lattice_scoreboard sb = new();
   int idle_cycles = 0;
   bit stall_on = 1'b0;

   adaptive_warped_lattice_analysis u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_in(req_sample_in), .req_buffer_slot(req_buffer_slot),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_stage_index(rsp_stage_index), .rsp_reflection_coef(rsp_reflection_coef),
      .rsp_residual_out(rsp_residual_out), .rsp_slot_out(rsp_slot_out),
      .rsp_last_result(rsp_last_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Check every accepted result at the rising edge; watchdog counts dead cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_stage_index, rsp_reflection_coef, rsp_residual_out,
                            rsp_slot_out, rsp_last_result);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || psel) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver stalls in runs of its own: toggle between stalled and open phases
   always @(negedge clock) begin
      if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
      rsp_ready <= stall_on ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 9) != 0);
   end

   // Write one register: setup cycle, then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == 3'd0) sb.set_leak(data[23:0]);
      else if (addr == 3'd4) sb.set_warp(data[23:0]);
   endtask

   // Present one item and hold it until accepted
   task automatic send_sample(input logic signed [23:0] smp, input logic [15:0] slot);
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_buffer_slot <= slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(smp, slot);
      @(negedge clock);
   endtask

   // Lower valid after a burst and idle for a random gap
   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Wait until every expected result has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_burst(input int count);
      int left;
      left = count;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 6);
         for (int k = 0; k < burst && left > 0; k++) begin
            logic signed [23:0] s;
            case ($urandom_range(0, 5))
               0: s = 24'sh7FFFFF;
               1: s = 24'sh800000;
               2: s = 24'($urandom_range(0, 255)) - 24'sd128;
               default: s = 24'($urandom);
            endcase
            send_sample(s, 16'($urandom));
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 400));
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes at reset settings, overflow of the emphasis path
      send_sample(24'sh7FFFFF, 16'hFFFF);
      send_sample(24'sh800000, 16'h0000);
      send_sample(24'sh7FFFFF, 16'h5555);
      send_sample(24'sh800000, 16'hAAAA);
      send_sample(24'sd0, 16'd1);
      send_sample(24'sd0, 16'd2);
      send_sample(24'sd1, 16'd3);
      send_sample(-24'sd1, 16'd4);
      drain();

      // Extremes of the leak and warp: no smoothing, then full smoothing, full warp either way
      csr_write(3'd0, 32'd0);
      csr_write(3'd4, 32'h007FFFFF);
      send_sample(24'sh7FFFFF, 16'd10);
      send_sample(24'sh000010, 16'd11);
      send_sample(24'sh800000, 16'd12);
      drain();
      csr_write(3'd0, 32'h00FFFFFF);
      csr_write(3'd4, 32'h00800000);
      send_sample(24'sh400000, 16'd20);
      send_sample(24'shC00000, 16'd21);
      send_sample(24'sh7FFFFF, 16'd22);
      drain();
      // Half leak with the warp switched off
      csr_write(3'd0, 32'd8388608);
      csr_write(3'd4, 32'd0);
      send_sample(24'sh123456, 16'd30);
      send_sample(24'shFEDCBA, 16'd31);
      drain();

      // Random phases across several settings, starting from the reset values
      csr_write(3'd0, 32'd16568289);
      csr_write(3'd4, 32'hFF8FE910);
      random_burst(50);
      drain();
      csr_write(3'd0, $urandom_range(0, 24'hFFFFFF));
      csr_write(3'd4, {8'h00, 24'($urandom)});
      random_burst(50);
      drain();
      csr_write(3'd0, 32'd16000000);
      csr_write(3'd4, 32'd3000000);
      random_burst(50);
      drain();
      repeat (400) @(negedge clock);

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/awla_pkg.sv
hw/rtl/awla_mac.sv
hw/rtl/awla_div.sv
hw/rtl/adaptive_warped_lattice_analysis.sv
tb/adaptive_warped_lattice_analysis_test.sv
